>>> rtl/core/lbs_pkg.sv
`default_nettype none
package lbs_pkg;
    localparam int NUM_BONES_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [1:0] OP_WR_BONE = 2'd0;
    localparam logic [1:0] OP_WR_BIND = 2'd1;
    localparam logic [1:0] OP_ADD     = 2'd2;
    localparam logic [1:0] OP_EMIT    = 2'd3;

    localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic ovf32(input logic signed [47:0] x);
        return (x > 48'sh0000_7FFF_FFFF) || (x < -48'sh0000_8000_0000);
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/linear_blend_skinning_unit.sv
`default_nettype none
// Linear blend skinning unit.
// Items are presented with i_start; one is taken at a clock edge where i_start
// is high and o_busy is low. Opcodes 0 and 1 load one element of the bone or
// bind table (no result). Opcode 2 adds a weighted influence for one bone
// slot: bind*v then bone*t, 16 multiply-accumulate steps per pass on one
// shared 32x32 multiplier reading one table word per cycle from the registered
// read port, then three weight products; o_busy stays high until the last
// weight product is added, so no new item is taken before then. Opcode 3
// emits the accumulator saturated to 32 bits on o_result_* with o_clipped,
// marked by o_valid for exactly one cycle, registered out of the emit state
// that the item enters, and clears the accumulator.
// The receiver cannot stall; results are never held.
// Reset clears the accumulator and control; table contents are undefined
// until written. Items are handled one at a time.
module linear_blend_skinning_unit
    import lbs_pkg::*;
#(
    parameter int NUM_BONES = NUM_BONES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [5:0]         i_table_bone,
    input  wire logic [3:0]         i_element_index,
    input  wire logic signed [31:0] i_element_value,
    input  wire logic [5:0]         i_influence_bone,
    input  wire logic [16:0]        i_influence_weight,
    input  wire logic signed [31:0] i_vertex_x,
    input  wire logic signed [31:0] i_vertex_y,
    input  wire logic signed [31:0] i_vertex_z,
    input  wire logic               i_direction_only,
    output logic                    o_valid,
    output logic signed [31:0]      o_result_x,
    output logic signed [31:0]      o_result_y,
    output logic signed [31:0]      o_result_z,
    output logic                    o_clipped
);
    localparam int BW    = 6;
    localparam int AW    = BW + 4;
    localparam int DEPTH = ((NUM_BONES < 64) ? NUM_BONES : 64) * 16;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAT   = 3'd1;
    localparam logic [2:0] ST_WGT   = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;

    logic [2:0]  r_state, n_state;
    logic        r_pass;          // 0 bind pass, 1 bone pass
    logic [4:0]  r_cnt;           // element read issue counter
    logic        r_rv;            // read data valid
    logic [3:0]  r_rel;           // element of the data in flight
    logic [BW-1:0] r_bone;
    logic [16:0] r_w;
    logic signed [31:0] r_v [4];
    logic signed [31:0] r_t [4];
    logic signed [63:0] r_sum;
    logic signed [47:0] r_acc [3];
    logic [1:0]  r_wi;
    logic        r_emit_d;

    wire logic acc_item = i_start && !o_busy;
    wire logic bone_ok  = ({3'b0, i_table_bone} < 9'(NUM_BONES));
    wire logic ibone_ok = ({3'b0, i_influence_bone} < 9'(NUM_BONES));

    logic        we_bone, we_bind;
    logic [AW-1:0] waddr, raddr;
    logic [31:0] rd_bone, rd_bind;

    assign waddr   = {i_table_bone, i_element_index};
    assign we_bone = acc_item && i_opcode == OP_WR_BONE && bone_ok;
    assign we_bind = acc_item && i_opcode == OP_WR_BIND && bone_ok;
    assign raddr   = {r_bone, r_cnt[3:0]};

    lbs_mat_mem #(.DEPTH(DEPTH), .AW(AW)) u_bone (
        .i_clk(i_clk), .i_we(we_bone), .i_waddr(waddr), .i_wdata(i_element_value),
        .i_raddr(raddr), .o_rdata(rd_bone));
    lbs_mat_mem #(.DEPTH(DEPTH), .AW(AW)) u_bind (
        .i_clk(i_clk), .i_we(we_bind), .i_waddr(waddr), .i_wdata(i_element_value),
        .i_raddr(raddr), .o_rdata(rd_bind));

    // Shared multiplier, one product per cycle.
    logic signed [31:0] mop_a, mop_b;
    logic signed [63:0] prod, prod_sh;
    logic signed [47:0] contrib, acc_sum_in;
    logic signed [48:0] acc_sum;

    always_comb begin
        mop_a = r_pass ? $signed(rd_bone) : $signed(rd_bind);
        mop_b = r_pass ? r_t[r_rel[1:0]] : r_v[r_rel[1:0]];
        if (r_state == ST_WGT) begin
            mop_a = r_t[r_wi];
            mop_b = $signed({15'd0, r_w});
        end
        prod    = mop_a * mop_b;
        prod_sh = prod >>> FRAC_BITS;
        contrib = prod_sh[47:0];
        acc_sum_in = r_acc[r_wi];
        acc_sum = {acc_sum_in[47], acc_sum_in} + {contrib[47], contrib};
    end

    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_item && i_opcode == OP_ADD && ibone_ok) n_state = ST_MAT;
                else if (acc_item && i_opcode == OP_EMIT) n_state = ST_EMIT;
            end
            ST_MAT:  if (r_pass && r_rv && r_rel == 4'd15) n_state = ST_WGT;
            ST_WGT:  if (r_wi == 2'd2) n_state = ST_IDLE;
            ST_EMIT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rv     <= 1'b0;
            r_cnt    <= '0;
            r_pass   <= 1'b0;
            r_wi     <= '0;
            r_emit_d <= 1'b0;
            o_valid  <= 1'b0;
            for (int k = 0; k < 3; k++) r_acc[k] <= '0;
        end else begin
            r_state  <= n_state;
            o_valid  <= 1'b0;
            r_emit_d <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    r_rv  <= 1'b0;
                    r_pass <= 1'b0;
                    r_wi  <= '0;
                    r_sum <= '0;
                    if (acc_item) begin
                        r_bone <= i_influence_bone;
                        r_w    <= i_influence_weight;
                        r_v[0] <= i_vertex_x;
                        r_v[1] <= i_vertex_y;
                        r_v[2] <= i_vertex_z;
                        r_v[3] <= i_direction_only ? 32'sd0 : 32'sd1 <<< FRAC_BITS;
                    end
                end
                ST_MAT: begin
                    // issue reads
                    r_rv  <= (r_cnt < 5'd16);
                    r_rel <= r_cnt[3:0];
                    if (r_cnt < 5'd16) r_cnt <= r_cnt + 5'd1;
                    if (r_rv) begin
                        if (r_rel[1:0] == 2'd3) begin
                            r_sum <= '0;
                            if (r_pass) r_v[r_rel[3:2]] <= sat32(r_sum + prod_sh);
                            else r_t[r_rel[3:2]] <= sat32(r_sum + prod_sh);
                        end else begin
                            r_sum <= r_sum + prod_sh;
                        end
                        if (!r_pass && r_rel == 4'd15) begin
                            r_pass <= 1'b1;
                            r_cnt  <= '0;
                            r_rv   <= 1'b0;
                        end
                    end
                    if (r_pass && r_rv && r_rel == 4'd15) begin
                        r_t[0] <= r_v[0];
                        r_t[1] <= r_v[1];
                        r_t[2] <= r_v[2];
                    end
                end
                ST_WGT: begin
                    if (acc_sum > 49'(S48_MAX)) r_acc[r_wi] <= S48_MAX;
                    else if (acc_sum < 49'(S48_MIN)) r_acc[r_wi] <= S48_MIN;
                    else r_acc[r_wi] <= acc_sum[47:0];
                    r_wi <= r_wi + 2'd1;
                end
                ST_EMIT: begin
                    o_valid    <= 1'b1;
                    o_result_x <= sat32(64'(r_acc[0]));
                    o_result_y <= sat32(64'(r_acc[1]));
                    o_result_z <= sat32(64'(r_acc[2]));
                    o_clipped  <= ovf32(r_acc[0]) | ovf32(r_acc[1]) | ovf32(r_acc[2]);
                    r_emit_d   <= 1'b1;
                    for (int k = 0; k < 3; k++) r_acc[k] <= '0;
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_valid_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_emit_d) else $error("result without emit");
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_acc[0] == 48'sd0) else $error("accumulator not cleared");
    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy) else $error("busy during result");
`endif
endmodule
`default_nettype wire

>>> rtl/core/lbs_mat_mem.sv
`default_nettype none
// Matrix table: one write port, one registered read port.
module lbs_mat_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [31:0]        o_rdata
);
    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
